FILE: hw/rtl/fdm_pkg.sv
package fdm_pkg;

  localparam int unsigned MaxWidthDefault = 1024;
  localparam int unsigned CmpW = 13;
  localparam int unsigned FifoDepth = 2;

  typedef enum logic [1:0] {
    CFG_IMG_WIDTH      = 2'd0,
    CFG_IMG_HEIGHT     = 2'd1,
    CFG_DIFF_THRESHOLD = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] dx;
    logic [15:0] dy;
    logic [7:0]  vgray;
    logic [11:0] row;
    logic        interior;
  } item_t;

  typedef struct packed {
    logic [16:0] diff_down;
    logic [16:0] diff_up;
    logic [16:0] diff_left;
    logic [16:0] diff_right;
    logic [3:0]  occ_mask;
    logic [11:0] occ_row;
    logic [9:0]  occ_col;
    logic        occ_valid;
    logic [7:0]  vertical_gray;
    logic [7:0]  magnitude_gray;
  } result_t;

  function automatic logic [15:0] abs_diff16(logic [15:0] a, logic [15:0] b);
    logic [16:0] d;
    d = {a[15], a} - {b[15], b};
    abs_diff16 = d[16] ? 16'(-d) : d[15:0];
  endfunction

  function automatic logic [16:0] l1_diff(logic [31:0] p, logic [31:0] q);
    l1_diff = 17'(abs_diff16(p[15:0], q[15:0])) + 17'(abs_diff16(p[31:16], q[31:16]));
  endfunction

endpackage

FILE: hw/rtl/fdm_ram.sv
module fdm_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: hw/rtl/fdm_fifo.sv
module fdm_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] data_q [fdm_pkg::FifoDepth];
  logic             wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'(fdm_pkg::FifoDepth));
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = data_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: hw/rtl/fdm_front.sv
module fdm_front #(
  parameter int unsigned MaxWidth = fdm_pkg::MaxWidthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [15:0]                 flow_dx_i,
  input  logic [15:0]                 flow_dy_i,
  input  logic                        frame_start_i,
  input  logic [10:0]                 img_width_i,
  input  logic [11:0]                 img_height_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output fdm_pkg::item_t              q_item_o,
  output logic [$clog2(MaxWidth)-1:0] q_col_o
);

  localparam int unsigned ColW = $clog2(MaxWidth);

  logic [ColW-1:0]          col_q, col_d, c;
  logic [11:0]              row_q, row_d, r;
  logic [fdm_pkg::CmpW-1:0] w_eff, c_next, r_next;
  logic [16:0]              ady;
  logic [15:0]              ady_c;
  logic [21:0]              vprod;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    c = frame_start_i ? '0 : col_q;
    r = frame_start_i ? '0 : row_q;
    w_eff = (fdm_pkg::CmpW'(img_width_i) > fdm_pkg::CmpW'(MaxWidth)) ?
            fdm_pkg::CmpW'(MaxWidth) : fdm_pkg::CmpW'(img_width_i);
    c_next = fdm_pkg::CmpW'(c) + 1'b1;
    r_next = fdm_pkg::CmpW'(r) + 1'b1;
    if (c_next >= w_eff) begin
      col_d = '0;
      row_d = (r_next >= fdm_pkg::CmpW'(img_height_i)) ? 12'd0 : r_next[11:0];
    end else begin
      col_d = ColW'(c_next);
      row_d = r;
    end
    ady   = flow_dy_i[15] ? 17'(-{1'b1, flow_dy_i}) : {1'b0, flow_dy_i};
    ady_c = (ady > 17'd1536) ? 16'd1536 : ady[15:0];
    vprod = {1'b0, ady_c, 5'd0} + {3'd0, ady_c, 3'd0};
    q_item_o.dx       = flow_dx_i;
    q_item_o.dy       = flow_dy_i;
    q_item_o.vgray    = vprod[15:8];
    q_item_o.row      = r;
    q_item_o.interior = (r >= 12'd2) && (r < img_height_i) && (c >= ColW'(2)) &&
                        (fdm_pkg::CmpW'(c) < w_eff);
    q_col_o = c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= 12'd0;
    end else if (q_push_o) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

FILE: hw/rtl/fdm_back.sv
module fdm_back #(
  parameter int unsigned MaxWidth = fdm_pkg::MaxWidthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  output logic                        q_pop_o,
  input  fdm_pkg::item_t              q_item_i,
  input  logic [$clog2(MaxWidth)-1:0] q_col_i,
  input  logic [16:0]                 diff_threshold_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output fdm_pkg::result_t            out_res_o
);

  localparam int unsigned ColW = $clog2(MaxWidth);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_SUM  = 6'b000100,
    S_MASK = 6'b001000,
    S_ITER = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  fdm_pkg::item_t   item_q;
  logic [ColW-1:0]  col_q;
  logic [31:0]      sqx_q, sqy_q, dx_ext, dy_ext;
  logic [32:0]      sum_q;
  logic [38:0]      lim_q;
  logic [7:0]       g_q, t;
  logic [2:0]       bit_q;
  logic [15:0]      tsq;
  logic [31:0]      a1_q, a2_q, t1_q, cur1_q, a_rd, cur;
  logic [16:0]      d_q [4];
  logic [3:0]       mask_q;
  logic             ram_we;
  logic [ColW-1:0]  ram_addr;
  logic [63:0]      ram_rdata;
  logic             out_valid_q, load_out;
  fdm_pkg::result_t res_q;

  assign q_pop_o  = (state_q == S_IDLE) && !q_empty_i;
  assign ram_we   = (state_q == S_RD);
  assign ram_addr = (state_q == S_IDLE) ? q_col_i : col_q;
  assign a_rd     = ram_rdata[31:0];
  assign cur      = {item_q.dy, item_q.dx};
  assign dx_ext   = {{16{item_q.dx[15]}}, item_q.dx};
  assign dy_ext   = {{16{item_q.dy[15]}}, item_q.dy};
  assign t        = g_q | (8'd1 << bit_q);
  assign tsq      = {8'd0, t} * {8'd0, t};
  assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  fdm_ram #(
    .Width (64),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({a_rd, cur}),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (!q_empty_i) state_d = S_RD;
      S_RD:   state_d = S_SUM;
      S_SUM:  state_d = S_MASK;
      S_MASK: state_d = S_ITER;
      S_ITER: if (bit_q == 3'd0) state_d = S_DONE;
      S_DONE: if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
      col_q  <= q_col_i;
    end
    if (state_q == S_RD) begin
      sqx_q  <= 32'(dx_ext * dx_ext);
      sqy_q  <= 32'(dy_ext * dy_ext);
      d_q[0] <= fdm_pkg::l1_diff(a_rd, a1_q);
      d_q[1] <= fdm_pkg::l1_diff(a2_q, a1_q);
      d_q[2] <= fdm_pkg::l1_diff(t1_q, a1_q);
      d_q[3] <= fdm_pkg::l1_diff(cur1_q, a1_q);
      a2_q   <= a1_q;
      a1_q   <= a_rd;
      t1_q   <= ram_rdata[63:32];
      cur1_q <= cur;
    end
    if (state_q == S_SUM) begin
      sum_q <= 33'(sqx_q) + 33'(sqy_q);
      for (int k = 0; k < 4; k++) begin
        mask_q[k] <= (d_q[k] >= diff_threshold_i);
      end
    end
    if (state_q == S_MASK) begin
      lim_q <= 39'({sum_q, 6'd0}) + 39'({sum_q, 5'd0}) + 39'({sum_q, 2'd0});
      g_q   <= 8'd0;
      bit_q <= 3'd7;
    end
    if (state_q == S_ITER) begin
      if ({7'd0, tsq, 16'd0} <= lim_q) begin
        g_q <= t;
      end
      bit_q <= bit_q - 3'd1;
    end
    if (load_out) begin
      res_q.magnitude_gray <= g_q;
      res_q.vertical_gray  <= item_q.vgray;
      res_q.occ_valid      <= item_q.interior;
      res_q.occ_col        <= item_q.interior ? 10'(32'(col_q) - 32'd1) : 10'd0;
      res_q.occ_row        <= item_q.interior ? 12'(item_q.row - 12'd1) : 12'd0;
      res_q.occ_mask       <= item_q.interior ? mask_q : 4'd0;
      res_q.diff_right     <= item_q.interior ? d_q[0] : 17'd0;
      res_q.diff_left      <= item_q.interior ? d_q[1] : 17'd0;
      res_q.diff_up        <= item_q.interior ? d_q[2] : 17'd0;
      res_q.diff_down      <= item_q.interior ? d_q[3] : 17'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("back state not one-hot");
  a_pop_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == S_RD))
    else $error("read phase missing after pop");
  a_wr_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> !ram_we)
    else $error("line store written twice for one transaction");
  a_vgray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.vertical_gray <= 8'd240))
    else $error("vertical gray out of range");
  a_occ_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.occ_valid) |-> (res_q.occ_row != 12'd0))
    else $error("interior pixel on top row");
`endif

endmodule

FILE: hw/rtl/flow_discontinuity_marker.sv
// Channel   Direction  Transaction
// s_axis    in         tdata: flow_dx, flow_dy; tuser: frame_start
// m_axis    out        tdata: gray levels, occlusion position, mask, four diffs
// cfg       in         write enable, register index, 17-bit data
//
// In the back end each transaction takes one line-store read, one write,
// and eight square-root steps on an 8x8 multiplier; a new one starts once the last is done.
// The front end takes one transaction per cycle into a two-entry queue while the queue is not full.
// Reset clears the counters, queue and state and loads the default configuration; the line stores are not cleared.
// Either side may stall; the output register holds a result until it is taken.
module flow_discontinuity_marker #(
  parameter int unsigned MaxWidth = fdm_pkg::MaxWidthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,  // flow_dx[15:0], flow_dy[31:16]
  input  logic         s_axis_tuser,  // frame_start
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // magnitude_gray, vertical_gray, occ_valid, occ_col, occ_row, occ_mask,
  // diff_right, diff_left, diff_up, diff_down, zero pad
  output logic [111:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [16:0]  cfg_data_i
);

  localparam int unsigned ColW = $clog2(MaxWidth);
  localparam int unsigned QW = $bits(fdm_pkg::item_t) + ColW;

  logic [10:0]      img_width_q;
  logic [11:0]      img_height_q;
  logic [16:0]      diff_threshold_q;
  logic             q_full, q_empty, q_push, q_pop;
  fdm_pkg::item_t   f_item, b_item;
  logic [ColW-1:0]  f_col, b_col;
  logic [QW-1:0]    q_rdata;
  fdm_pkg::result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q      <= 11'd640;
      img_height_q     <= 12'd480;
      diff_threshold_q <= 17'd154;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fdm_pkg::CFG_IMG_WIDTH:      img_width_q      <= cfg_data_i[10:0];
        fdm_pkg::CFG_IMG_HEIGHT:     img_height_q     <= cfg_data_i[11:0];
        fdm_pkg::CFG_DIFF_THRESHOLD: diff_threshold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fdm_front #(.MaxWidth(MaxWidth)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .flow_dx_i     (s_axis_tdata[15:0]),
    .flow_dy_i     (s_axis_tdata[31:16]),
    .frame_start_i (s_axis_tuser),
    .img_width_i   (img_width_q),
    .img_height_i  (img_height_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (f_item),
    .q_col_o       (f_col)
  );

  fdm_fifo #(.Width(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_col, f_item}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (q_rdata)
  );

  assign b_item = q_rdata[$bits(fdm_pkg::item_t)-1:0];
  assign b_col  = q_rdata[QW-1:$bits(fdm_pkg::item_t)];

  fdm_back #(.MaxWidth(MaxWidth)) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_pop_o          (q_pop),
    .q_item_i         (b_item),
    .q_col_i          (b_col),
    .diff_threshold_i (diff_threshold_q),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_res_o        (res)
  );

  assign m_axis_tdata = {1'b0, res};

endmodule
